// ===== hdl/round_robin_ready_worker_table_defines.svh =====
// Assertion macros used by the round-robin ready-worker table RTL.
`ifndef ROUND_ROBIN_READY_WORKER_TABLE_DEFINES_SVH
`define ROUND_ROBIN_READY_WORKER_TABLE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk_i, disabled during reset.
`define RRWT_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("worker table assertion failed");
// Next-cycle implication, sampled on clk_i, disabled during reset.
`define RRWT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("worker table assertion failed");
`else
`define RRWT_ASSERT(lbl, ante, cons)
`define RRWT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/rrwt_pkg.sv =====
// Package with the types, codes and constants of the round-robin ready-worker table.
`timescale 1ns / 1ps
`default_nettype none
package rrwt_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 16;

  localparam int unsigned ACTION_W = 3;
  localparam int unsigned ID_W     = 16;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned PORT_W   = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned TOTAL_W  = 5;

  localparam logic [HANDLE_W-1:0] NO_HANDLE = {HANDLE_W{1'b1}};

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD       = 3'd0,
    ACT_REMOVE    = 3'd1,
    ACT_SET_RDY   = 3'd2,
    ACT_SET_NRDY  = 3'd3,
    ACT_UPD_PORT  = 3'd4,
    ACT_NEXT      = 3'd5,
    ACT_LOOKUP    = 3'd6,
    ACT_LINK_LOST = 3'd7
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOCHANGE  = 3'd1,
    ST_NOTFOUND  = 3'd2,
    ST_FULL      = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_INVALID   = 3'd5,
    ST_NONEREADY = 3'd6
  } status_e;

  typedef enum logic {
    MATCH_ID    = 1'b0,
    MATCH_READY = 1'b1
  } match_mode_e;

  // One table entry as it is stored in the memory.
  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [HANDLE_W-1:0] handle;
    logic [PORT_W-1:0]   port;
    logic                connected;
    logic                ready;
  } entry_t;

  // Request to the shared compare unit.
  typedef struct packed {
    match_mode_e     mode;
    logic [ID_W-1:0] key;
  } match_req_t;

endpackage
`default_nettype wire

// ===== hdl/rrwt_in_if.sv =====
// Request channel interface of the worker table: valid, ready and the request fields.
`timescale 1ns / 1ps
`default_nettype none
interface rrwt_in_if;
  import rrwt_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [ID_W-1:0]     worker_id;
  logic [HANDLE_W-1:0] handle;
  logic [PORT_W-1:0]   peer_port;

  modport source (output valid, output action, output worker_id, output handle,
                  output peer_port, input ready);
  modport sink (input valid, input action, input worker_id, input handle,
                input peer_port, output ready);
endinterface
`default_nettype wire

// ===== hdl/rrwt_out_if.sv =====
// Result channel interface of the worker table: valid, ready and the result fields.
`timescale 1ns / 1ps
`default_nettype none
interface rrwt_out_if;
  import rrwt_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     found_id;
  logic [HANDLE_W-1:0] found_handle;
  logic [PORT_W-1:0]   found_port;
  logic                found_connected;
  logic                found_ready;
  logic [TOTAL_W-1:0]  worker_total;

  modport source (output valid, output status, output found_id, output found_handle,
                  output found_port, output found_connected, output found_ready,
                  output worker_total, input ready);
  modport sink (input valid, input status, input found_id, input found_handle,
                input found_port, input found_connected, input found_ready,
                input worker_total, output ready);
endinterface
`default_nettype wire

// ===== hdl/rrwt_mem.sv =====
// Entry memory of the worker table: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module rrwt_mem #(
  parameter int unsigned DEPTH = rrwt_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  rrwt_pkg::entry_t wdata_i,
  input  logic [AW-1:0]   raddr_i,
  output rrwt_pkg::entry_t rdata_o
);
  import rrwt_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ===== hdl/rrwt_match.sv =====
// Shared compare unit: tests one entry for an id match or for a selectable worker.
`timescale 1ns / 1ps
`default_nettype none
module rrwt_match (
  input  rrwt_pkg::match_req_t req_i,
  input  rrwt_pkg::entry_t     entry_i,
  output logic                 hit_o
);
  import rrwt_pkg::*;

  always_comb begin
    case (req_i.mode)
      MATCH_ID:    hit_o = (entry_i.id == req_i.key);
      MATCH_READY: hit_o = entry_i.connected & entry_i.ready;
      default:     hit_o = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/round_robin_ready_worker_table.sv =====
// Top level of the round-robin ready-worker table: sequencer, result register, checks.
`timescale 1ns / 1ps
`default_nettype none
// The block keeps an ordered table of up to MAX_ENTRIES workers in a single-port-write,
// registered-read memory. Requests arrive on req_i and each request gives exactly one
// transaction on res_o, in request order. req_i.ready is high only while the sequencer is
// idle, so one request is worked on at a time; a finished result waits in the output
// register while the next request is already being taken and scanned.
// Add needs no search. Lookup, set ready, set not ready, update port and link lost
// search from the head; next worker scans from the rotation pointer; remove searches
// from the head and then closes the gap behind the removed entry. All cost comes from
// the memory port: one entry is read per cycle and checked by the shared compare unit,
// and the gap after a removal is closed one entry per cycle.
// Reset clears the entry count, the rotation pointer and the handshake state; the memory
// contents are not cleared since only positions below the entry count are ever read.
// When the receiver stalls, the result stays on res_o; a later request can still be
// taken and worked on, but its result is held inside until the output register frees.
`include "round_robin_ready_worker_table_defines.svh"
module round_robin_ready_worker_table #(
  parameter int unsigned MAX_ENTRIES = rrwt_pkg::MAX_ENTRIES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  rrwt_in_if.sink           req_i,
  rrwt_out_if.source        res_o
);
  import rrwt_pkg::*;

  localparam int unsigned IW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  // Control state.
  logic [2:0]    state_q, state_d;
  logic [CW-1:0] total_q, total_d;
  logic [IW-1:0] rot_q, rot_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          cmp_vld_q, cmp_vld_d;
  logic          wvld_q, wvld_d;
  logic          out_valid_q, out_valid_d;

  // Request and working registers.
  action_e             act_q, act_d;
  logic [ID_W-1:0]     key_q, key_d;
  logic [HANDLE_W-1:0] hnd_q, hnd_d;
  logic [PORT_W-1:0]   port_q, port_d;
  logic [IW-1:0]       pos_q, pos_d;
  logic [IW-1:0]       cmp_pos_q, cmp_pos_d;
  logic                hit_q, hit_d;
  logic [IW-1:0]       hit_pos_q, hit_pos_d;
  entry_t              ent_q, ent_d;
  logic [CW-1:0]       sh_rd_q, sh_rd_d;
  logic [IW-1:0]       wpos_q, wpos_d;
  status_e             res_status_q, res_status_d;
  entry_t              res_ent_q, res_ent_d;

  // Output register.
  status_e            out_status_q, out_status_d;
  entry_t             out_ent_q, out_ent_d;
  logic [TOTAL_W-1:0] out_total_q, out_total_d;

  // Memory and compare unit connections.
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic [IW-1:0] mem_raddr;
  entry_t        mem_rdata;
  match_req_t    mreq;
  logic          mhit;

  // Pointer arithmetic; sums are taken in count width so a value equal to the depth is visible.
  logic [CW-1:0] pos_inc;
  logic [IW-1:0] pos_wrap;
  logic [CW-1:0] hit_inc;
  logic [IW-1:0] rot_after_next;
  logic [CW-1:0] rot_ext;
  logic [CW-1:0] rot_dec;
  logic [CW-1:0] total_dec;
  logic [IW-1:0] rot_after_rm;
  logic [CW-1:0] sh_rd_dec;
  logic          out_free;
  logic          want_ready;

  assign pos_inc        = CW'(pos_q) + 1'b1;
  assign pos_wrap       = (pos_inc >= total_q) ? '0 : pos_inc[IW-1:0];
  assign hit_inc        = CW'(hit_pos_q) + 1'b1;
  assign rot_after_next = (hit_inc >= total_q) ? '0 : hit_inc[IW-1:0];
  assign rot_ext        = CW'(rot_q);
  assign total_dec      = total_q - 1'b1;
  // Removing an entry before the pointer keeps the pointer on the same worker; removing
  // the entry under the pointer leaves it on the following one, wrapping to the head.
  assign rot_dec        = (CW'(hit_pos_q) < rot_ext) ? (rot_ext - 1'b1) : rot_ext;
  assign rot_after_rm   = (rot_dec >= total_dec) ? '0 : rot_dec[IW-1:0];
  assign sh_rd_dec      = sh_rd_q - 1'b1;
  assign out_free       = !out_valid_q || res_o.ready;
  assign want_ready     = (act_q == ACT_SET_RDY);

  assign mreq.mode = (act_q == ACT_NEXT) ? MATCH_READY : MATCH_ID;
  assign mreq.key  = key_q;

  rrwt_mem #(
    .DEPTH (MAX_ENTRIES),
    .AW    (IW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  rrwt_match u_match (
    .req_i   (mreq),
    .entry_i (mem_rdata),
    .hit_o   (mhit)
  );

  always_comb begin
    state_d      = state_q;
    total_d      = total_q;
    rot_d        = rot_q;
    cnt_d        = cnt_q;
    cmp_vld_d    = cmp_vld_q;
    wvld_d       = wvld_q;
    out_valid_d  = out_valid_q && !res_o.ready;
    act_d        = act_q;
    key_d        = key_q;
    hnd_d        = hnd_q;
    port_d       = port_q;
    pos_d        = pos_q;
    cmp_pos_d    = cmp_pos_q;
    hit_d        = hit_q;
    hit_pos_d    = hit_pos_q;
    ent_d        = ent_q;
    sh_rd_d      = sh_rd_q;
    wpos_d       = wpos_q;
    res_status_d = res_status_q;
    res_ent_d    = res_ent_q;
    out_status_d = out_status_q;
    out_ent_d    = out_ent_q;
    out_total_d  = out_total_q;
    mem_we       = 1'b0;
    mem_waddr    = hit_pos_q;
    mem_wdata    = ent_q;
    mem_raddr    = pos_q;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          act_d     = action_e'(req_i.action);
          key_d     = req_i.worker_id;
          hnd_d     = req_i.handle;
          port_d    = req_i.peer_port;
          cnt_d     = '0;
          cmp_vld_d = 1'b0;
          wvld_d    = 1'b0;
          hit_d     = 1'b0;
          pos_d     = (action_e'(req_i.action) == ACT_NEXT) ? rot_q : '0;
          state_d   = (action_e'(req_i.action) == ACT_ADD) ? S_EXEC : S_SCAN;
        end
      end

      S_SCAN: begin
        // Read one entry per cycle; the compare unit checks the entry read the cycle
        // before, so the scan stops on the first hit in scan order.
        mem_raddr = pos_q;
        if (cnt_q < total_q) begin
          cmp_vld_d = 1'b1;
          cmp_pos_d = pos_q;
          pos_d     = pos_wrap;
          cnt_d     = cnt_q + 1'b1;
        end else begin
          cmp_vld_d = 1'b0;
        end
        if (cmp_vld_q && mhit) begin
          hit_d     = 1'b1;
          hit_pos_d = cmp_pos_q;
          ent_d     = mem_rdata;
          cmp_vld_d = 1'b0;
          state_d   = S_EXEC;
        end else if (cnt_q == total_q) begin
          hit_d     = 1'b0;
          cmp_vld_d = 1'b0;
          state_d   = S_EXEC;
        end
      end

      S_EXEC: begin
        res_status_d = ST_OK;
        res_ent_d    = '0;
        state_d      = S_OUT;
        case (act_q)
          ACT_ADD: begin
            if (hnd_q == NO_HANDLE) begin
              res_status_d = ST_INVALID;
            end else if (total_q >= MAX_CNT) begin
              res_status_d = ST_FULL;
            end else begin
              mem_we              = 1'b1;
              mem_waddr           = total_q[IW-1:0];
              mem_wdata.id        = key_q;
              mem_wdata.handle    = hnd_q;
              mem_wdata.port      = port_q;
              mem_wdata.connected = 1'b1;
              mem_wdata.ready     = 1'b0;
              total_d             = total_q + 1'b1;
            end
          end
          ACT_REMOVE: begin
            if (key_q == '0) begin
              res_status_d = ST_INVALID;
            end else if (total_q == '0) begin
              res_status_d = ST_EMPTY;
            end else if (!hit_q) begin
              res_status_d = ST_NOTFOUND;
            end else begin
              sh_rd_d = hit_inc;
              wvld_d  = 1'b0;
              state_d = S_SHIFT;
            end
          end
          ACT_SET_RDY, ACT_SET_NRDY: begin
            if (!hit_q) begin
              res_status_d = ST_NOTFOUND;
            end else if (ent_q.ready == want_ready) begin
              res_status_d = ST_NOCHANGE;
            end else begin
              mem_we          = 1'b1;
              mem_wdata.ready = want_ready;
            end
          end
          ACT_UPD_PORT: begin
            if (!hit_q) begin
              res_status_d = ST_NOTFOUND;
            end else begin
              mem_we         = 1'b1;
              mem_wdata.port = port_q;
            end
          end
          ACT_NEXT: begin
            if (total_q == '0) begin
              res_status_d = ST_EMPTY;
            end else if (!hit_q) begin
              res_status_d = ST_NONEREADY;
            end else begin
              res_ent_d = ent_q;
              rot_d     = rot_after_next;
            end
          end
          ACT_LOOKUP: begin
            if (!hit_q) begin
              res_status_d = ST_NOTFOUND;
            end else begin
              res_ent_d = ent_q;
            end
          end
          ACT_LINK_LOST: begin
            if (!hit_q) begin
              res_status_d = ST_NOTFOUND;
            end else if (!ent_q.connected) begin
              res_status_d = ST_NOCHANGE;
            end else begin
              mem_we              = 1'b1;
              mem_wdata.connected = 1'b0;
              mem_wdata.handle    = NO_HANDLE;
            end
          end
          default: begin
            res_status_d = ST_INVALID;
          end
        endcase
      end

      S_SHIFT: begin
        // Close the gap: read entry k + 1 in one cycle, write it to k in the next.
        mem_raddr = sh_rd_q[IW-1:0];
        if (wvld_q) begin
          mem_we    = 1'b1;
          mem_waddr = wpos_q;
          mem_wdata = mem_rdata;
        end
        if (sh_rd_q < total_q) begin
          wvld_d  = 1'b1;
          wpos_d  = sh_rd_dec[IW-1:0];
          sh_rd_d = sh_rd_q + 1'b1;
        end else begin
          wvld_d  = 1'b0;
          total_d = total_dec;
          rot_d   = rot_after_rm;
          state_d = S_OUT;
        end
      end

      S_OUT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_ent_d    = res_ent_q;
          out_total_d  = TOTAL_W'(total_q);
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      total_q     <= '0;
      rot_q       <= '0;
      cnt_q       <= '0;
      cmp_vld_q   <= 1'b0;
      wvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      rot_q       <= rot_d;
      cnt_q       <= cnt_d;
      cmp_vld_q   <= cmp_vld_d;
      wvld_q      <= wvld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q        <= act_d;
    key_q        <= key_d;
    hnd_q        <= hnd_d;
    port_q       <= port_d;
    pos_q        <= pos_d;
    cmp_pos_q    <= cmp_pos_d;
    hit_q        <= hit_d;
    hit_pos_q    <= hit_pos_d;
    ent_q        <= ent_d;
    sh_rd_q      <= sh_rd_d;
    wpos_q       <= wpos_d;
    res_status_q <= res_status_d;
    res_ent_q    <= res_ent_d;
    out_status_q <= out_status_d;
    out_ent_q    <= out_ent_d;
    out_total_q  <= out_total_d;
  end

  assign req_i.ready           = (state_q == S_IDLE);
  assign res_o.valid           = out_valid_q;
  assign res_o.status          = out_status_q;
  assign res_o.found_id        = out_ent_q.id;
  assign res_o.found_handle    = out_ent_q.handle;
  assign res_o.found_port      = out_ent_q.port;
  assign res_o.found_connected = out_ent_q.connected;
  assign res_o.found_ready     = out_ent_q.ready;
  assign res_o.worker_total    = out_total_q;

  // The rotation pointer always names a stored entry, or the head of an empty table.
  `RRWT_ASSERT(a_rot_in_range, 1'b1, rot_q == '0 || rot_ext < total_q)
  // An accepted request always starts the sequencer.
  `RRWT_ASSERT_NEXT(a_accept_busy, req_i.valid && req_i.ready, state_q != S_IDLE)
  // The entry count only moves when an add executes or a removal finishes.
  `RRWT_ASSERT_NEXT(a_total_hold, state_q != S_EXEC && state_q != S_SHIFT, $stable(total_q))

endmodule
`default_nettype wire

// ===== tb/round_robin_ready_worker_table_tb.sv =====
// Self-checking testbench of the round-robin ready-worker table.
`timescale 1ns / 1ps
module round_robin_ready_worker_table_tb;
  import rrwt_pkg::*;

  // The table depth of the block under test; the testbench keeps its own copy of the
  // table at the same depth.
  localparam int MAX_ENTRIES = MAX_ENTRIES_DEF;

  // Longest quiet time after the last result: a full search plus a gap closing pass,
  // with some margin.
  localparam int DRAIN_CYCLES = 2 * MAX_ENTRIES + 16;

  // Hard limit on the run, in clock cycles of 2 ns.
  localparam int TIMEOUT_CYCLES = 1_000_000;

  // Number of mismatch lines that are printed; later ones are only counted.
  localparam int PRINT_LIMIT = 40;

  // One expected transaction on the result channel.
  typedef struct packed {
    status_e             status;
    logic [ID_W-1:0]     id;
    logic [HANDLE_W-1:0] handle;
    logic [PORT_W-1:0]   port;
    logic                connected;
    logic                ready;
    logic [TOTAL_W-1:0]  total;
  } worker_result_t;

  logic clk_i;
  logic rst_ni;

  rrwt_in_if  req_if ();
  rrwt_out_if res_if ();

  round_robin_ready_worker_table DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  // The testbench's own copy of the worker table. Entries are packed from position 0,
  // in the order in which they were added.
  logic [ID_W-1:0]     w_id     [MAX_ENTRIES];
  logic [HANDLE_W-1:0] w_handle [MAX_ENTRIES];
  logic [PORT_W-1:0]   w_port   [MAX_ENTRIES];
  logic                w_conn   [MAX_ENTRIES];
  logic                w_rdy    [MAX_ENTRIES];
  int                  n_workers;
  int                  rot_pos;

  // Results that the block still owes, oldest first.
  worker_result_t pending_results [$];

  // Idling controls of the current phase, in percent of cycles.
  int send_idle_pct;
  int recv_stall_pct;

  // A nonzero value asks the receiver process to hold off for that many cycles.
  int hold_request;

  // Bookkeeping for the summary.
  int errors;
  int requests_sent;
  int results_checked;
  int full_hits;
  int worker_picks;
  int none_ready_hits;
  int action_seen [8];

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Position of the first entry with this id counting from the head, or n_workers when
  // no entry carries it.
  function automatic int find_worker(logic [ID_W-1:0] id);
    int p;
    for (p = 0; p < n_workers; p++) begin
      if (w_id[p] == id) return p;
    end
    return n_workers;
  endfunction

  // All found fields of the entry at one position, with status ok.
  function automatic worker_result_t entry_view(int pos);
    worker_result_t r;
    r = '0;
    r.status    = ST_OK;
    r.id        = w_id[pos];
    r.handle    = w_handle[pos];
    r.port      = w_port[pos];
    r.connected = w_conn[pos];
    r.ready     = w_rdy[pos];
    return r;
  endfunction

  // Applies one request to the table copy and returns the transaction that the block
  // has to answer with. Found fields stay zero whenever no entry is reported.
  function automatic worker_result_t apply_worker_action(
    action_e act, logic [ID_W-1:0] id, logic [HANDLE_W-1:0] hnd, logic [PORT_W-1:0] port
  );
    worker_result_t r;
    int pos;
    int k;
    bit hit;
    r = '0;
    r.status = ST_OK;
    pos = find_worker(id);
    case (act)
      ACT_ADD: begin
        if (hnd == NO_HANDLE) begin
          r.status = ST_INVALID;
        end else if (n_workers >= MAX_ENTRIES) begin
          r.status = ST_FULL;
        end else begin
          w_id[n_workers]     = id;
          w_handle[n_workers] = hnd;
          w_port[n_workers]   = port;
          w_conn[n_workers]   = 1'b1;
          w_rdy[n_workers]    = 1'b0;
          if (n_workers == 0) rot_pos = 0;
          n_workers++;
        end
      end
      ACT_REMOVE: begin
        if (id == '0) begin
          r.status = ST_INVALID;
        end else if (n_workers == 0) begin
          r.status = ST_EMPTY;
        end else if (pos >= n_workers) begin
          r.status = ST_NOTFOUND;
        end else begin
          for (k = pos; k + 1 < n_workers; k++) begin
            w_id[k]     = w_id[k+1];
            w_handle[k] = w_handle[k+1];
            w_port[k]   = w_port[k+1];
            w_conn[k]   = w_conn[k+1];
            w_rdy[k]    = w_rdy[k+1];
          end
          n_workers--;
          // The pointer stays on the same entry, or moves on to the one that follows
          // the removed entry.
          if (pos < rot_pos) rot_pos--;
          if (rot_pos >= n_workers) rot_pos = 0;
        end
      end
      ACT_SET_RDY, ACT_SET_NRDY: begin
        if (pos >= n_workers) begin
          r.status = ST_NOTFOUND;
        end else if (w_rdy[pos] == (act == ACT_SET_RDY)) begin
          r.status = ST_NOCHANGE;
        end else begin
          w_rdy[pos] = (act == ACT_SET_RDY);
        end
      end
      ACT_UPD_PORT: begin
        if (pos >= n_workers) r.status = ST_NOTFOUND;
        else w_port[pos] = port;
      end
      ACT_NEXT: begin
        if (n_workers == 0) begin
          r.status = ST_EMPTY;
        end else begin
          pos = rot_pos;
          hit = 1'b0;
          for (k = 0; k < n_workers && !hit; k++) begin
            if (pos >= n_workers) pos = 0;
            if (w_conn[pos] && w_rdy[pos]) hit = 1'b1;
            else pos++;
          end
          if (!hit) begin
            r.status = ST_NONEREADY;
          end else begin
            r = entry_view(pos);
            rot_pos = (pos + 1 >= n_workers) ? 0 : pos + 1;
          end
        end
      end
      ACT_LOOKUP: begin
        if (pos >= n_workers) r.status = ST_NOTFOUND;
        else r = entry_view(pos);
      end
      default: begin
        if (pos >= n_workers) begin
          r.status = ST_NOTFOUND;
        end else if (!w_conn[pos]) begin
          r.status = ST_NOCHANGE;
        end else begin
          w_conn[pos]   = 1'b0;
          w_handle[pos] = NO_HANDLE;
        end
      end
    endcase
    r.total = n_workers[TOTAL_W-1:0];
    return r;
  endfunction

  // Prints one mismatch line, up to a limit, and counts every mismatch.
  task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    if (errors <= PRINT_LIMIT) begin
      $display("%0t ns: mismatch in result %0d, %s: got 0x%0h, expected 0x%0h",
               $realtime, results_checked, what, got, want);
    end
  endtask

  // Sends one request. The sender may idle first, as the phase asks; valid then stays
  // high until the block takes the transaction. The expected result is worked out at
  // the edge where the transaction is accepted.
  task automatic send_item(action_e act, logic [ID_W-1:0] id, logic [HANDLE_W-1:0] hnd,
                           logic [PORT_W-1:0] port);
    worker_result_t want;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    req_if.valid     <= 1'b1;
    req_if.action    <= act;
    req_if.worker_id <= id;
    req_if.handle    <= hnd;
    req_if.peer_port <= port;
    do @(posedge clk_i); while (!req_if.ready);
    want = apply_worker_action(act, id, hnd, port);
    pending_results.push_back(want);
    requests_sent++;
    action_seen[act]++;
    if (want.status == ST_FULL) full_hits++;
    if (want.status == ST_NONEREADY) none_ready_hits++;
    if (act == ACT_NEXT && want.status == ST_OK) worker_picks++;
  endtask

  // Stops offering requests and waits until the block has delivered every result that
  // is owed. It always lets at least one edge pass, so valid is lowered only once in a
  // time step.
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // Receiver: ready is drawn at random each cycle, except during a requested hold-off,
  // which is counted down here.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Checker: every result transaction is compared with the oldest expectation.
  always @(posedge clk_i) begin
    worker_result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        note_mismatch("result with nothing expected", 64'(res_if.status), 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (res_if.status != want.status)
          note_mismatch("status", 64'(res_if.status), 64'(want.status));
        if (res_if.found_id != want.id)
          note_mismatch("found_id", 64'(res_if.found_id), 64'(want.id));
        if (res_if.found_handle != want.handle)
          note_mismatch("found_handle", 64'(res_if.found_handle), 64'(want.handle));
        if (res_if.found_port != want.port)
          note_mismatch("found_port", 64'(res_if.found_port), 64'(want.port));
        if (res_if.found_connected != want.connected)
          note_mismatch("found_connected", 64'(res_if.found_connected),
                        64'(want.connected));
        if (res_if.found_ready != want.ready)
          note_mismatch("found_ready", 64'(res_if.found_ready), 64'(want.ready));
        if (res_if.worker_total != want.total)
          note_mismatch("worker_total", 64'(res_if.worker_total), 64'(want.total));
      end
      results_checked++;
    end
  end

  // Every action but add on an empty table, and a remove with the invalid id 0.
  task automatic test_empty_table();
    send_item(ACT_NEXT, 16'd0, 32'd0, 16'd0);
    send_item(ACT_REMOVE, 16'd7, 32'd0, 16'd0);
    send_item(ACT_REMOVE, 16'd0, 32'd0, 16'd0);
    send_item(ACT_LOOKUP, 16'd1, 32'd0, 16'd0);
    send_item(ACT_SET_RDY, 16'd1, 32'd0, 16'd0);
    send_item(ACT_SET_NRDY, 16'd1, 32'd0, 16'd0);
    send_item(ACT_UPD_PORT, 16'd1, 32'd0, 16'hFFFF);
    send_item(ACT_LINK_LOST, 16'd1, 32'd0, 16'd0);
  endtask

  // Adds at the field extremes with a duplicate id, then the ready flag, port update,
  // lookup and link loss on the first of the two duplicates. A worker that lost its link
  // keeps its ready flag but is no longer selected.
  task automatic test_add_and_flags();
    send_item(ACT_ADD, 16'd5, NO_HANDLE, 16'd9);
    send_item(ACT_ADD, 16'hFFFF, 32'd0, 16'hFFFF);
    send_item(ACT_ADD, 16'd0, 32'hFFFF_FFFE, 16'd0);
    send_item(ACT_ADD, 16'hFFFF, 32'h1234_5678, 16'h1234);
    send_item(ACT_NEXT, 16'd0, 32'd0, 16'd0);
    send_item(ACT_SET_RDY, 16'hFFFF, 32'd0, 16'd0);
    send_item(ACT_SET_RDY, 16'hFFFF, 32'd0, 16'd0);
    send_item(ACT_SET_NRDY, 16'd0, 32'd0, 16'd0);
    send_item(ACT_UPD_PORT, 16'hFFFF, 32'd0, 16'd0);
    send_item(ACT_LOOKUP, 16'hFFFF, 32'd0, 16'd0);
    send_item(ACT_NEXT, 16'd0, 32'd0, 16'd0);
    send_item(ACT_LINK_LOST, 16'hFFFF, 32'd0, 16'd0);
    send_item(ACT_LINK_LOST, 16'hFFFF, 32'd0, 16'd0);
    send_item(ACT_NEXT, 16'd0, 32'd0, 16'd0);
    send_item(ACT_REMOVE, 16'h0BAD, 32'd0, 16'd0);
  endtask

  // The receiver holds off for a long stretch while the sender keeps adding workers, so
  // the result path backs up into the request channel. The table is filled to the top
  // and one more add is refused as full.
  task automatic test_fill_under_backpressure();
    int i;
    hold_request = 120;
    i = 0;
    while (n_workers < MAX_ENTRIES) begin
      send_item(ACT_ADD, 16'd100 + i[ID_W-1:0], $urandom(),
                PORT_W'($urandom_range(65535)));
      i++;
    end
    send_item(ACT_ADD, 16'd200, $urandom(), 16'd0);
    wait_drained();
  endtask

  // Round-robin selection on the full table, with removals after the rotation pointer and
  // a wrap back to the head.
  task automatic test_rotation_and_removal();
    send_item(ACT_SET_RDY, 16'd103, 32'd0, 16'd0);
    send_item(ACT_SET_RDY, 16'd110, 32'd0, 16'd0);
    send_item(ACT_SET_RDY, 16'd0, 32'd0, 16'd0);
    send_item(ACT_NEXT, 16'd0, 32'd0, 16'd0);
    send_item(ACT_NEXT, 16'd0, 32'd0, 16'd0);
    send_item(ACT_NEXT, 16'd0, 32'd0, 16'd0);
    send_item(ACT_NEXT, 16'd0, 32'd0, 16'd0);
    send_item(ACT_REMOVE, 16'd103, 32'd0, 16'd0);
    send_item(ACT_NEXT, 16'd0, 32'd0, 16'd0);
    send_item(ACT_REMOVE, 16'd112, 32'd0, 16'd0);
    send_item(ACT_LOOKUP, 16'd111, 32'd0, 16'd0);
    send_item(ACT_NEXT, 16'd0, 32'd0, 16'd0);
  endtask

  // Random traffic under one idling setting. Most ids are taken from workers in the table
  // so that searches hit; the rest come from a small pool, which makes duplicates likely,
  // or from the whole id range. Adds and removes are steered so that the table keeps
  // moving between nearly empty and full.
  task automatic test_random_traffic(int send_pct, int stall_pct, int items);
    int i;
    int r;
    action_e act;
    logic [ID_W-1:0] id;
    logic [HANDLE_W-1:0] hnd;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    for (i = 0; i < items; i++) begin
      r = $urandom_range(99);
      if (r < 25) act = ACT_ADD;
      else if (r < 37) act = ACT_REMOVE;
      else if (r < 52) act = ACT_SET_RDY;
      else if (r < 60) act = ACT_SET_NRDY;
      else if (r < 66) act = ACT_UPD_PORT;
      else if (r < 84) act = ACT_NEXT;
      else if (r < 92) act = ACT_LOOKUP;
      else act = ACT_LINK_LOST;
      if (act == ACT_ADD && n_workers >= 12 && $urandom_range(1) == 1) act = ACT_REMOVE;
      else if (act == ACT_REMOVE && n_workers <= 3 && $urandom_range(1) == 1) act = ACT_ADD;
      r = $urandom_range(99);
      if (r < 70 && n_workers > 0) id = w_id[$urandom_range(n_workers - 1)];
      else if (r < 92) id = ID_W'($urandom_range(23));
      else id = ID_W'($urandom_range(65535));
      hnd = ($urandom_range(19) == 0) ? NO_HANDLE : $urandom();
      send_item(act, id, hnd, PORT_W'($urandom_range(65535)));
    end
    // The sender pauses here until every owed result has come.
    wait_drained();
  endtask

  initial begin
    errors          = 0;
    requests_sent   = 0;
    results_checked = 0;
    full_hits       = 0;
    worker_picks    = 0;
    none_ready_hits = 0;
    hold_request    = 0;
    n_workers       = 0;
    rot_pos         = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    foreach (action_seen[a]) action_seen[a] = 0;
    rst_ni           <= 1'b0;
    req_if.valid     <= 1'b0;
    req_if.action    <= ACT_ADD;
    req_if.worker_id <= '0;
    req_if.handle    <= '0;
    req_if.peer_port <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_add_and_flags();
    test_fill_under_backpressure();
    test_rotation_and_removal();
    wait_drained();

    // Random phases: no idling, an idle sender, a stalling receiver, then both.
    test_random_traffic(0, 0, 320);
    test_random_traffic(49, 0, 300);
    test_random_traffic(0, 49, 300);
    test_random_traffic(12, 12, 300);

    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d requests (add %0d, remove %0d, next %0d), %0d results checked.",
             requests_sent, action_seen[ACT_ADD], action_seen[ACT_REMOVE],
             action_seen[ACT_NEXT], results_checked);
    $display("Full table refused %0d adds, %0d workers picked, %0d scans found none ready.",
             full_hits, worker_picks, none_ready_hits);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results never arrived.", errors, pending_results.size());
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: a run that hangs on a handshake ends here as a failure.
  initial begin
    #(2.0 * TIMEOUT_CYCLES);
    $display("Timeout with %0d results still owed.", pending_results.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== round_robin_ready_worker_table.f =====
+incdir+hdl
hdl/rrwt_pkg.sv
hdl/rrwt_in_if.sv
hdl/rrwt_out_if.sv
hdl/rrwt_mem.sv
hdl/rrwt_match.sv
hdl/round_robin_ready_worker_table.sv
tb/round_robin_ready_worker_table_tb.sv
